// File: rtl/core/iqddc_pkg.sv
`timescale 1ns / 1ps

package iqddc_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = 10;
	localparam int QTR         = TABLE_DEPTH / 4;
	localparam int QTR_W       = 8;
	localparam int DC_SHIFT    = 7;
	localparam int DC_W        = 20;
	localparam int ADC_W       = 12;
	localparam int S_W         = 14;
	localparam int TRIG_W      = 16;
	localparam int MAG_W       = 15;
	localparam int PROD_W      = 30;
	localparam int ROT_SHIFT   = 15;
	localparam int ROT_W       = 15;
	localparam int INTEG_W     = 18;
	localparam int OUT_W       = 15;
	localparam int PHASE_W     = 32;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;
	localparam int FIFO_CNT_W  = 3;

	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam logic REG_TUNING_WORD = 1'b0;
	localparam logic [PHASE_W-1:0] TUNING_RST = 32'h4000_0000;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 15'sh3fff;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 15'sh4000;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;

	typedef logic [MAG_W-1:0] qsin_tab_t [QTR];

	typedef struct packed {
		logic signed [S_W-1:0] s;
		logic                  odd;
		logic [IDX_W-1:0]      idx;
	} item_t;

	// truncating divide by a positive divisor, shift and subtract, table build only
	function automatic longint div_trunc(input longint a, input longint b);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		logic [63:0] rem;
		num = (a < 0) ? 64'(-a) : 64'(a);
		den = 64'(b);
		quo = '0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[62:0], num[k]};
			if (rem >= den) begin
				rem = rem - den;
				quo[k] = 1'b1;
			end
		end
		return (a < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	// round(32767 * sin(m / TABLE_DEPTH * pi/2)), Q30 taylor series, elaboration only
	function automatic logic [MAG_W-1:0] quarter_sine(input longint m);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint n;
		x = (m * HALF_PI_Q30 + TABLE_DEPTH / 2) / TABLE_DEPTH;
		x2 = (x * x) >>> 30;
		term = x;
		sum = x;
		for (n = 1; n < 20 && term != 0; n++) begin
			term = div_trunc(-(term * x2 / ONE_Q30), (2 * n) * (2 * n + 1));
			sum = sum + term;
		end
		if (sum < 0) begin
			sum = 0;
		end
		return MAG_W'((sum * 32767 + (ONE_Q30 / 2)) >>> 30);
	endfunction

	function automatic qsin_tab_t build_qsin();
		qsin_tab_t t;
		for (int j = 0; j < QTR; j++) begin
			t[j] = quarter_sine(longint'(4 * j));
		end
		return t;
	endfunction

	localparam qsin_tab_t QSIN = build_qsin();
	localparam logic [MAG_W-1:0] QSIN_PEAK = quarter_sine(longint'(TABLE_DEPTH));

	// full-wave sine from the quarter-wave table
	function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [IDX_W-1:0] idx);
		logic [1:0]       quad;
		logic [QTR_W-1:0] j;
		logic [MAG_W-1:0] mag;
		logic signed [TRIG_W-1:0] v;
		quad = idx[IDX_W-1 -: 2];
		j = idx[QTR_W-1:0];
		if (!quad[0]) begin
			mag = QSIN[j];
		end else if (j == '0) begin
			mag = QSIN_PEAK;
		end else begin
			mag = QSIN[QTR_W'(~j + 1'b1)];
		end
		v = signed'({1'b0, mag});
		return quad[1] ? -v : v;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [INTEG_W-1:0] d);
		logic [INTEG_W-OUT_W:0] top;
		top = d[INTEG_W-1:OUT_W-1];
		if (top == '0 || top == '1) begin
			return d[OUT_W-1:0];
		end else if (d[INTEG_W-1]) begin
			return OUT_MIN;
		end else begin
			return OUT_MAX;
		end
	endfunction

endpackage

// File: rtl/core/iqddc_front.sv
`timescale 1ns / 1ps

module iqddc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [iqddc_pkg::ADC_W-1:0]     adc_sample,
	input  logic [iqddc_pkg::PHASE_W-1:0]   tuning_word,
	input  logic                            fifo_full,
	output logic                            push,
	output iqddc_pkg::item_t                item
);
	import iqddc_pkg::*;

	logic signed [DC_W-1:0]  dc_q;
	logic [PHASE_W-1:0]      phase_q;
	logic                    odd_q;
	logic signed [ADC_W-1:0] raw;
	logic signed [DC_W-1:0]  dc_next;
	logic signed [DC_W-1:0]  dc_shr;

	assign in_ready = !fifo_full;
	assign push     = in_valid && in_ready;

	// offset binary to two's complement is an msb flip
	assign raw     = signed'({~adc_sample[ADC_W-1], adc_sample[ADC_W-2:0]});
	assign dc_next = dc_q + DC_W'(raw) - (dc_q >>> DC_SHIFT);
	assign dc_shr  = dc_next >>> DC_SHIFT;

	always_comb begin
		item.s   = S_W'(raw) - S_W'(dc_shr);
		item.odd = odd_q;
		item.idx = phase_q[PHASE_W-1 -: IDX_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q    <= '0;
			phase_q <= '0;
			odd_q   <= 1'b0;
		end else if (push) begin
			dc_q    <= dc_next;
			phase_q <= phase_q + tuning_word;
			odd_q   <= !odd_q;
		end
	end

endmodule

// File: rtl/core/iqddc_fifo.sv
`timescale 1ns / 1ps

module iqddc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  iqddc_pkg::item_t  wr_item,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output iqddc_pkg::item_t  rd_item
);
	import iqddc_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full      = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/iqddc_back.sv
`timescale 1ns / 1ps

module iqddc_back #(
	parameter int DECIMATION = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  fifo_valid,
	input  iqddc_pkg::item_t                      head,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [iqddc_pkg::OUT_W-1:0]    i_out,
	output logic signed [iqddc_pkg::OUT_W-1:0]    q_out
);
	import iqddc_pkg::*;

	localparam int CW = (DECIMATION > 2) ? $clog2(DECIMATION) : 1;

	logic                      en;
	logic                      v_s1;
	logic                      v_s2;
	logic                      odd_s1;
	logic                      odd_s2;
	logic signed [S_W-1:0]     s_s1;
	logic signed [TRIG_W-1:0]  sin_s1;
	logic signed [TRIG_W-1:0]  cos_s1;
	logic signed [PROD_W-1:0]  pc_s2;
	logic signed [PROD_W-1:0]  ps_s2;
	logic signed [PROD_W-1:0]  neg_ps;
	logic signed [ROT_W-1:0]   ri;
	logic signed [ROT_W-1:0]   rq;
	logic signed [INTEG_W-1:0] integ_i_q;
	logic signed [INTEG_W-1:0] integ_q_q;
	logic signed [INTEG_W-1:0] prev_i_q;
	logic signed [INTEG_W-1:0] prev_q_q;
	logic signed [INTEG_W-1:0] integ_i_n;
	logic signed [INTEG_W-1:0] integ_q_n;
	logic [CW-1:0]             cnt_q;
	logic                      last;
	logic                      emit;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   i_q;
	logic signed [OUT_W-1:0]   q_q;

	// whole back end holds while a finished beat waits at the output
	assign en  = !out_valid_q || out_ready;
	assign pop = en && fifo_valid;

	// mixing against exp(-j*phase) with one of i/q zero
	assign neg_ps    = -ps_s2;
	assign ri        = odd_s2 ? ROT_W'(ps_s2 >>> ROT_SHIFT) : ROT_W'(pc_s2 >>> ROT_SHIFT);
	assign rq        = odd_s2 ? ROT_W'(pc_s2 >>> ROT_SHIFT) : ROT_W'(neg_ps >>> ROT_SHIFT);
	assign integ_i_n = integ_i_q + INTEG_W'(ri);
	assign integ_q_n = integ_q_q + INTEG_W'(rq);
	assign last      = cnt_q == CW'(DECIMATION - 1);
	assign emit      = v_s2 && last;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= head.s;
			odd_s1 <= head.odd;
			sin_s1 <= sine_lookup(head.idx);
			cos_s1 <= sine_lookup(head.idx + IDX_W'(QTR));
			odd_s2 <= odd_s1;
			pc_s2  <= PROD_W'(s_s1) * PROD_W'(cos_s1);
			ps_s2  <= PROD_W'(s_s1) * PROD_W'(sin_s1);
			if (emit) begin
				i_q <= sat_out(integ_i_n - prev_i_q);
				q_q <= sat_out(integ_q_n - prev_q_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			integ_i_q   <= '0;
			integ_q_q   <= '0;
			prev_i_q    <= '0;
			prev_q_q    <= '0;
		end else if (en) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			out_valid_q <= emit;
			if (v_s2) begin
				integ_i_q <= integ_i_n;
				integ_q_q <= integ_q_n;
				cnt_q     <= last ? '0 : cnt_q + 1'b1;
				if (last) begin
					prev_i_q <= integ_i_n;
					prev_q_q <= integ_q_n;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign i_out     = i_q;
	assign q_out     = q_q;

endmodule

// File: rtl/core/iq_downconverter_cic_decimator.sv
`timescale 1ns / 1ps

// iq down-converter: 12-bit offset-binary adc samples, alternately i then q, go through
// dc removal (leaky integrator, shift 7), rotation by a 32-bit nco over a quarter-wave
// q15 sine table, and a first-order cic that gives one complex beat every DECIMATION
// accepted samples. one sample per clock is taken sustained while no result beat is held. an
// accepted sample is classified in the front (dc removal, i/q slot, nco phase) in its accept
// cycle and queued in a 4-beat queue; the back end takes the table read, the multiply and the
// integrate/comb in three register stages, so a result beat is registered once the sample
// that completes it has passed the table read and multiply. only a held result beat stops the
// back end; the queue then fills and in_ready drops. tuning_word sits at byte address 0 of the
// apb port, resets to 0x40000000 and should be written only while the block is idle.
module iq_downconverter_cic_decimator #(
	parameter int DECIMATION = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [iqddc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [iqddc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [iqddc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [iqddc_pkg::ADC_W-1:0]         adc_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [iqddc_pkg::OUT_W-1:0]  i_out,
	output logic signed [iqddc_pkg::OUT_W-1:0]  q_out
);
	import iqddc_pkg::*;

	logic [PHASE_W-1:0] tuning_q;
	logic               reg_sel;
	logic               fifo_full;
	logic               fifo_not_empty;
	logic               push;
	logic               pop;
	item_t              wr_item;
	item_t              head;

	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1] == REG_TUNING_WORD;
	assign prdata  = reg_sel ? tuning_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_q <= TUNING_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tuning_q <= pwdata;
		end
	end

	iqddc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.adc_sample  (adc_sample),
		.tuning_word (tuning_q),
		.fifo_full   (fifo_full),
		.push        (push),
		.item        (wr_item)
	);

	iqddc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (wr_item),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (fifo_not_empty),
		.rd_item   (head)
	);

	iqddc_back #(
		.DECIMATION (DECIMATION)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.i_out      (i_out),
		.q_out      (q_out)
	);

endmodule
